### rtl/cpr_pkg.sv
// shared types, constants and zone transition table for the cpr global decoder
package cpr_pkg;

   localparam int LAT_ZONES = 15;
   localparam int NL_MAX = 59;
   localparam int NL_STEPS = 58;
   localparam int ANG_BITS = 32;

   // degrees*1e-8 test: mag * DEG_SCALE >= edge << EDGE_SHIFT
   localparam logic [24:0] DEG_SCALE = 25'd17578125;
   localparam int EDGE_SHIFT = 21;
   localparam int PROD_BITS = 57;
   localparam int EDGE_BITS = PROD_BITS - EDGE_SHIFT;

   localparam logic [ANG_BITS-1:0] ANG_270 = 32'hC000_0000;

   // transition latitudes in units of 1e-8 degree, ascending
   localparam logic [EDGE_BITS-1:0] NL_EDGE [NL_STEPS] = '{
      36'd1047047130, 36'd1482817437, 36'd1818626357, 36'd2102939493, 36'd2354504487,
      36'd2582924707, 36'd2793898710, 36'd2991135686, 36'd3177209708, 36'd3353993436,
      36'd3522899598, 36'd3685025108, 36'd3841241892, 36'd3992256684, 36'd4138651832,
      36'd4280914012, 36'd4419454951, 36'd4554626723, 36'd4686733252, 36'd4816039128,
      36'd4942776439, 36'd5067150166, 36'd5189342469, 36'd5309516153, 36'd5427817472,
      36'd5544378444, 36'd5659318756, 36'd5772747354, 36'd5884763776, 36'd5995459277,
      36'd6104917774, 36'd6213216659, 36'd6320427479, 36'd6426616523, 36'd6531845310,
      36'd6636171008, 36'd6739646774, 36'd6842322022, 36'd6944242631, 36'd7045451075,
      36'd7145986473, 36'd7245884545, 36'd7345177442, 36'd7443893416, 36'd7542056257,
      36'd7639684391, 36'd7736789461, 36'd7833374083, 36'd7929428225, 36'd8024923213,
      36'd8119801349, 36'd8213956981, 36'd8307199445, 36'd8399173563, 36'd8489166191,
      36'd8575541621, 36'd8653536998, 36'd8700000000
   };

   typedef struct packed {
      logic [16:0] even_lat_code;
      logic [16:0] even_lon_code;
      logic [16:0] odd_lat_code;
      logic [16:0] odd_lon_code;
      logic        latest_is_odd;
   } req_word_type;

   typedef struct packed {
      logic               status;
      logic signed [31:0] latitude;
      logic [31:0]        longitude;
   } rsp_word_type;

endpackage

### rtl/cpr_global_position_decoder_top.sv
// Global airborne CPR position decoder. One word enters per clock unless the output
// stalls. Its result leaves after 2 input stages, 3 stages that form both zone latitudes
// by reciprocal multiplication, 5 stages for the zone count NL and the longitude index,
// and a 39-stage longitude divider that makes one quotient bit per stage. Throughput is
// one word per cycle without a stall. A stall on rsp_ freezes the whole pipeline,
// so req_stall follows a held result directly. A pair that straddles a zone boundary
// returns status 1 with latitude and longitude zero.
module cpr_global_position_decoder_top #(
   parameter int CODE_BITS = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cpr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cpr_pkg::rsp_word_type rsp_word
);

   localparam int NB = CODE_BITS;
   localparam int ZL = 4 * cpr_pkg::LAT_ZONES;
   localparam int TW = NB + 8;
   localparam int LSH = 33 - NB;
   localparam int DW = 7;
   localparam int LAT_QW = 32;
   localparam int LON_QW = 39;
   localparam int LAT_SW = 2 * NB + 1;
   localparam int LON_SW = 33;
   localparam int MX_BITS = 12;
   localparam int GROUPS = 8;
   localparam int PW = cpr_pkg::PROD_BITS;
   localparam int ES = cpr_pkg::EDGE_SHIFT;
   localparam int NS = cpr_pkg::NL_STEPS;
   // reciprocal widths: zone index split, then the rounded fraction of one zone
   localparam int W1 = NB + 6;
   localparam int S1 = W1 + 6;
   localparam int P1W = 2 * W1 + 1;
   localparam int W2 = LSH + 6;
   localparam int S2 = W2 + 7;
   localparam int P2W = 2 * W2 + 1;

   logic adv;

   // input stage
   logic          a_valid_ff;
   logic [NB-1:0] a_yz0_ff, a_xz0_ff, a_yz1_ff, a_xz1_ff;
   logic          a_odd_ff;

   // latitude index
   logic [TW-1:0] t_lat;
   logic          b_valid_ff;
   logic [6:0]    b_j_ff, b_j_in;
   logic [NB-1:0] b_yz0_ff, b_xz0_ff, b_yz1_ff, b_xz1_ff;
   logic          b_odd_ff;

   logic [5:0]    jm_e, jm_o;

   // zone latitudes, lanes 0 even, 1 odd
   logic [W1-1:0]     lat_n [2];
   logic [P1W-1:0]    h_prod_in [2];
   logic              h_valid_ff;
   logic [P1W-1:0]    h_prod_ff [2];
   logic [W1-1:0]     h_n_ff [2];
   logic [LAT_SW-1:0] h_side_ff;
   logic [NB-1:0]     i_b_in [2];
   logic [W1-1:0]     i_rem [2];
   logic              i_valid_ff;
   logic [NB-1:0]     i_b_ff [2];
   logic [5:0]        i_c_ff [2];
   logic [LAT_SW-1:0] i_side_ff;
   logic [P2W-1:0]    k_prod_in [2];
   logic              k_valid_ff;
   logic [P2W-1:0]    k_prod_ff [2];
   logic [NB-1:0]     k_b_ff [2];
   logic [LAT_SW-1:0] k_side_ff;

   logic                      ld_valid;
   logic [1:0][LAT_QW-1:0]    ld_quot;
   logic [LAT_SW-1:0]         ld_side;

   // zone count lanes: 0 even, 1 odd
   logic              c_valid_ff;
   logic [PW-1:0]     c_prod_ff [2];
   logic [31:0]       c_lat_ff [2];
   logic [LAT_SW-1:0] c_side_ff;
   logic [31:0]       c_mag [2];

   logic              d_valid_ff;
   logic [NS-1:0]     d_hit_ff [2];
   logic [NS-1:0]     d_hit_in [2];
   logic [31:0]       d_lat_ff [2];
   logic [LAT_SW-1:0] d_side_ff;

   logic              e_valid_ff;
   logic [3:0]        e_grp_ff [2][GROUPS];
   logic [3:0]        e_grp_in [2][GROUPS];
   logic [31:0]       e_lat_ff [2];
   logic [LAT_SW-1:0] e_side_ff;

   logic              f_valid_ff;
   logic [5:0]        f_nl_ff [2];
   logic [5:0]        f_nl_in [2];
   logic [31:0]       f_lat_ff [2];
   logic [LAT_SW-1:0] f_side_ff;

   // longitude index stage
   logic [NB-1:0] f_xz0, f_xz1;
   logic          f_odd;
   logic [5:0]    nlm1;
   logic [TW-1:0] t_lon;
   logic          g_valid_ff;
   logic          g_status_ff, g_status_in;
   logic [5:0]    g_ni_ff, g_ni_in;
   logic [6:0]    g_m_ff;
   logic [NB-1:0] g_xz_ff;
   logic [31:0]   g_lat_ff, g_lat_in;

   logic [MX_BITS:0]          mx_wide;
   logic [MX_BITS-1:0]        mx;
   logic [0:0][LON_QW+DW-1:0] lon_num;
   logic [0:0][DW-1:0]        lon_den;
   logic [0:0][LON_QW-1:0]    lon_quot;
   logic [LON_SW-1:0]         lon_side;

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_yz0_ff <= NB'(req_word.even_lat_code);
         a_xz0_ff <= NB'(req_word.even_lon_code);
         a_yz1_ff <= NB'(req_word.odd_lat_code);
         a_xz1_ff <= NB'(req_word.odd_lon_code);
         a_odd_ff <= req_word.latest_is_odd;
      end
   end

   // ---------------- stage B: j = floor((59*yz0 - 60*yz1 + half) / 2^nb)
   assign t_lat = TW'(a_yz0_ff) * TW'(ZL - 1) - TW'(a_yz1_ff) * TW'(ZL)
                + (TW'(1) << (NB - 1));
   assign b_j_in = t_lat[NB+6:NB];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_j_ff <= b_j_in;
         b_yz0_ff <= a_yz0_ff;
         b_xz0_ff <= a_xz0_ff;
         b_yz1_ff <= a_yz1_ff;
         b_xz1_ff <= a_xz1_ff;
         b_odd_ff <= a_odd_ff;
      end
   end

   // floored j mod 60 and j mod 59, j in -60..59
   assign jm_e = b_j_ff[6] ? 6'(b_j_ff + 7'(ZL)) : 6'(b_j_ff);
   always_comb begin
      if (b_j_ff == 7'(-ZL)) begin
         jm_o = 6'(ZL - 2);
      end else if (b_j_ff[6]) begin
         jm_o = 6'(b_j_ff + 7'(ZL - 1));
      end else if (b_j_ff == 7'(ZL - 1)) begin
         jm_o = '0;
      end else begin
         jm_o = 6'(b_j_ff);
      end
   end

   // round(n * 2^32 / (z * 2^nb)) = floor((n << (33-nb) + z) / 2z); with n = z*b + c
   // this is b << (32-nb) plus floor((c << (33-nb) + z) / 2z), both by reciprocals
   for (genvar l = 0; l < 2; l++) begin : g_lat
      localparam int Z = (l == 0) ? ZL : ZL - 1;
      localparam logic [63:0] RCP1 = ((64'd1 << S1) + 64'(Z) - 64'd1) / 64'(Z);
      localparam logic [63:0] RCP2 = ((64'd1 << S2) + 64'(2 * Z) - 64'd1) / 64'(2 * Z);
      if (l == 0) begin : g_even
         assign lat_n[l] = {jm_e, b_yz0_ff};
      end else begin : g_odd
         assign lat_n[l] = {jm_o, b_yz1_ff};
      end
      assign h_prod_in[l] = P1W'(lat_n[l]) * P1W'(RCP1[W1:0]);
      assign i_b_in[l] = h_prod_ff[l][S1+NB-1:S1];
      assign i_rem[l] = h_n_ff[l] - W1'(i_b_in[l]) * W1'(Z);
      assign k_prod_in[l] = P2W'({i_c_ff[l], LSH'(Z)}) * P2W'(RCP2[W2:0]);
      assign ld_quot[l] = {k_b_ff[l], k_prod_ff[l][S2+LSH-2:S2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= b_valid_ff;
         i_valid_ff <= h_valid_ff;
         k_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            h_prod_ff[l] <= h_prod_in[l];
            h_n_ff[l] <= lat_n[l];
            i_b_ff[l] <= i_b_in[l];
            i_c_ff[l] <= i_rem[l][5:0];
            k_prod_ff[l] <= k_prod_in[l];
            k_b_ff[l] <= i_b_ff[l];
         end
         h_side_ff <= {b_xz0_ff, b_xz1_ff, b_odd_ff};
         i_side_ff <= h_side_ff;
         k_side_ff <= i_side_ff;
      end
   end

   assign ld_valid = k_valid_ff;
   assign ld_side = k_side_ff;

   // ---------------- stage C: magnitude in degree units
   for (genvar l = 0; l < 2; l++) begin : g_mag
      // 270 degrees and up wraps to a negative latitude
      assign c_mag[l] = (ld_quot[l] >= cpr_pkg::ANG_270) ? 32'(0 - ld_quot[l]) : ld_quot[l];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= ld_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   // ---------------- stage D: compare against every transition latitude
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         for (int k = 0; k < NS; k++) begin
            if (k == NS - 1) begin
               // 87 degrees counts only when exceeded
               d_hit_in[l][k] = (c_prod_ff[l][PW-1:ES] > cpr_pkg::NL_EDGE[k])
                  || ((c_prod_ff[l][PW-1:ES] == cpr_pkg::NL_EDGE[k])
                      && (c_prod_ff[l][ES-1:0] != '0));
            end else begin
               d_hit_in[l][k] = c_prod_ff[l][PW-1:ES] >= cpr_pkg::NL_EDGE[k];
            end
         end
      end
   end

   // ---------------- stage E: partial counts over groups of eight
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         for (int g = 0; g < GROUPS; g++) begin
            e_grp_in[l][g] = '0;
            for (int b = 0; b < 8; b++) begin
               if (g * 8 + b < NS) begin
                  e_grp_in[l][g] = e_grp_in[l][g] + 4'(d_hit_ff[l][g*8+b]);
               end
            end
         end
      end
   end

   // ---------------- stage F: nl = 59 minus thresholds reached
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         f_nl_in[l] = 6'(cpr_pkg::NL_MAX);
         for (int g = 0; g < GROUPS; g++) begin
            f_nl_in[l] = f_nl_in[l] - 6'(e_grp_ff[l][g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            c_prod_ff[l] <= PW'(c_mag[l]) * PW'(cpr_pkg::DEG_SCALE);
            c_lat_ff[l] <= ld_quot[l];
            d_hit_ff[l] <= d_hit_in[l];
            d_lat_ff[l] <= c_lat_ff[l];
            for (int g = 0; g < GROUPS; g++) begin
               e_grp_ff[l][g] <= e_grp_in[l][g];
            end
            e_lat_ff[l] <= d_lat_ff[l];
            f_nl_ff[l] <= f_nl_in[l];
            f_lat_ff[l] <= e_lat_ff[l];
         end
         c_side_ff <= ld_side;
         d_side_ff <= c_side_ff;
         e_side_ff <= d_side_ff;
         f_side_ff <= e_side_ff;
      end
   end

   // ---------------- stage G: straddle check, ni and longitude index m
   assign f_xz0 = f_side_ff[2*NB:NB+1];
   assign f_xz1 = f_side_ff[NB:1];
   assign f_odd = f_side_ff[0];
   assign nlm1 = f_nl_ff[0] - 6'd1;
   assign t_lon = TW'(f_xz0) * TW'(nlm1) - TW'(f_xz1) * TW'(f_nl_ff[0])
                + (TW'(1) << (NB - 1));
   assign g_status_in = f_nl_ff[0] != f_nl_ff[1];
   assign g_ni_in = (f_nl_ff[0] <= 6'(f_odd)) ? 6'd1 : 6'(f_nl_ff[0] - 6'(f_odd));
   assign g_lat_in = g_status_in ? '0 : (f_odd ? f_lat_ff[1] : f_lat_ff[0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         g_status_ff <= g_status_in;
         g_ni_ff <= g_ni_in;
         g_m_ff <= t_lon[NB+6:NB];
         g_xz_ff <= f_odd ? f_xz1 : f_xz0;
         g_lat_ff <= g_lat_in;
      end
   end

   // m + 60*ni is positive and leaves the angle unchanged modulo 2^32
   assign mx_wide = (MX_BITS+1)'({{(MX_BITS-6){g_m_ff[6]}}, g_m_ff})
                  + (MX_BITS+1)'(g_ni_ff) * (MX_BITS+1)'(ZL);
   assign mx = mx_wide[MX_BITS-1:0];
   assign lon_num[0] = g_status_ff ? '0
                     : ((LON_QW+DW)'({mx, g_xz_ff}) << LSH) + (LON_QW+DW)'(g_ni_ff);
   assign lon_den[0] = {g_ni_ff, 1'b0};

   cpr_div #(
      .QW(LON_QW),
      .DW(DW),
      .LN(1),
      .SW(LON_SW)
   ) u_lon_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (g_valid_ff),
      .in_num   (lon_num),
      .in_den   (lon_den),
      .in_side  ({g_status_ff, g_lat_ff}),
      .out_valid(rsp_valid),
      .out_quot (lon_quot),
      .out_side (lon_side)
   );

   assign rsp_word.status = lon_side[32];
   assign rsp_word.latitude = signed'(lon_side[31:0]);
   assign rsp_word.longitude = lon_quot[0][31:0];

`ifndef SYNTHESIS
   a_straddle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status |-> rsp_word.latitude == 0 && rsp_word.longitude == 0)
      else $error("straddled pair gave nonzero position");

   a_nl_range: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> f_nl_ff[0] >= 6'd1 && f_nl_ff[0] <= 6'(cpr_pkg::NL_MAX)
                  && f_nl_ff[1] >= 6'd1 && f_nl_ff[1] <= 6'(cpr_pkg::NL_MAX))
      else $error("zone count out of range");

   a_ni_range: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff |-> g_ni_ff >= 6'd1 && g_ni_ff <= 6'(cpr_pkg::NL_MAX))
      else $error("longitude zone divisor out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(g_valid_ff) && $stable(c_valid_ff))
      else $error("pipeline moved while output held");
`endif

endmodule

### rtl/cpr_div.sv
// pipelined restoring divider, one quotient bit per stage, lanes share a sideband
module cpr_div #(
   parameter int QW = 32,
   parameter int DW = 7,
   parameter int LN = 1,
   parameter int SW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LN-1:0][QW+DW-1:0]    in_num,
   input  logic [LN-1:0][DW-1:0]       in_den,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [LN-1:0][QW-1:0]       out_quot,
   output logic [SW-1:0]               out_side
);

   logic [QW-1:0] valid_ff;
   logic [QW-1:0] valid_in;
   logic [SW-1:0] side_ff [QW];
   logic [SW-1:0] side_in [QW];
   logic [DW-1:0] rem_ff [QW][LN];
   logic [DW-1:0] rem_in [QW][LN];
   logic [DW-1:0] rem_cur [QW][LN];
   logic [DW-1:0] den_ff [QW][LN];
   logic [DW-1:0] den_in [QW][LN];
   // dividend bits leave at the top, quotient bits enter at the bottom
   logic [QW-1:0] acc_ff [QW][LN];
   logic [QW-1:0] acc_in [QW][LN];
   logic [QW-1:0] acc_cur [QW][LN];
   logic [DW:0]   trial [QW][LN];
   logic          take [QW][LN];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign valid_in[k] = in_valid;
         assign side_in[k] = in_side;
         for (genvar l = 0; l < LN; l++) begin : g_src
            assign rem_cur[k][l] = in_num[l][QW+DW-1:QW];
            assign acc_cur[k][l] = in_num[l][QW-1:0];
            assign den_in[k][l] = in_den[l];
         end
      end else begin : g_next
         assign valid_in[k] = valid_ff[k-1];
         assign side_in[k] = side_ff[k-1];
         for (genvar l = 0; l < LN; l++) begin : g_src
            assign rem_cur[k][l] = rem_ff[k-1][l];
            assign acc_cur[k][l] = acc_ff[k-1][l];
            assign den_in[k][l] = den_ff[k-1][l];
         end
      end
      for (genvar l = 0; l < LN; l++) begin : g_lane
         assign trial[k][l] = {rem_cur[k][l], acc_cur[k][l][QW-1]};
         assign take[k][l] = trial[k][l] >= {1'b0, den_in[k][l]};
         assign rem_in[k][l] = take[k][l] ? DW'(trial[k][l] - {1'b0, den_in[k][l]})
                                          : trial[k][l][DW-1:0];
         assign acc_in[k][l] = {acc_cur[k][l][QW-2:0], take[k][l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            side_ff[k] <= side_in[k];
            for (int l = 0; l < LN; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               den_ff[k][l] <= den_in[k][l];
               acc_ff[k][l] <= acc_in[k][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_side = side_ff[QW-1];
   for (genvar l = 0; l < LN; l++) begin : g_out
      assign out_quot[l] = acc_ff[QW-1][l];
   end

endmodule
